// ===== hw/rtl/vtpd_pkg.sv =====
// Shared types, widths and register codes of the vertex transform block.
package vtpd_pkg;

	localparam int CompW  = 32;
	localparam int CoefW  = 16;
	localparam int RowW   = 4 * CoefW;
	localparam int ProdW  = CompW + CoefW;
	localparam int SumW   = ProdW + 2;
	localparam int FracSh = 12;
	localparam int RndW   = SumW - FracSh;
	localparam int MagW   = RndW;
	localparam int NumW   = MagW + 16;
	localparam int QW     = 33;
	localparam int DivLat = QW + 1;
	localparam int CfgIdxW = 3;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_ROW0 = 3'd0,
		CFG_ROW1 = 3'd1,
		CFG_ROW2 = 3'd2,
		CFG_ROW3 = 3'd3,
		CFG_DIV  = 3'd4
	} cfg_idx_t;

	localparam logic [RowW-1:0] Row0Reset = 64'h0000_0000_0000_1000;
	localparam logic [RowW-1:0] Row1Reset = 64'h0000_0000_1000_0000;
	localparam logic [RowW-1:0] Row2Reset = 64'h0000_1000_0000_0000;
	localparam logic [RowW-1:0] Row3Reset = 64'h1000_0000_0000_0000;

	typedef logic signed [CompW-1:0] comp_t;
	typedef logic [RndW-1:0] rnd_t;

	typedef struct packed {
		rnd_t [3:0] r;
		logic       div;
		logic [2:0] neg;
	} side_t;

endpackage

// ===== hw/rtl/vtpd_dot.sv =====
// One matrix row times the vertex: multiply, add tree and rounding to Q16.16.
module vtpd_dot (
	input  logic                       clk,
	input  logic                       en,
	input  logic [vtpd_pkg::RowW-1:0]  row,
	input  vtpd_pkg::comp_t            v [4],
	output logic [vtpd_pkg::RndW-1:0]  r
);
	import vtpd_pkg::*;

	logic signed [ProdW-1:0]  prod_s1 [4];
	logic signed [ProdW:0]    pair_s2 [2];
	logic signed [SumW-1:0]   sum;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 4; j++) begin
				prod_s1[j] <= $signed(row[CoefW*j +: CoefW]) * v[j];
			end
			pair_s2[0] <= (ProdW+1)'(prod_s1[0]) + (ProdW+1)'(prod_s1[1]);
			pair_s2[1] <= (ProdW+1)'(prod_s1[2]) + (ProdW+1)'(prod_s1[3]);
		end
	end

	assign sum = SumW'(pair_s2[0]) + SumW'(pair_s2[1]) + SumW'(2048);

	always_ff @(posedge clk) begin
		if (en) begin
			r <= sum[SumW-1:FracSh];
		end
	end
endmodule

// ===== hw/rtl/vtpd_divider.sv =====
// Pipelined restoring divider giving (a << 16) / b to 33 bits with overflow.
module vtpd_divider (
	input  logic                      clk,
	input  logic                      en,
	input  logic [vtpd_pkg::MagW-1:0] mag_a,
	input  logic [vtpd_pkg::MagW-1:0] mag_b,
	output logic [vtpd_pkg::QW-1:0]   quo,
	output logic                      ovf
);
	import vtpd_pkg::*;

	logic [NumW-1:0] rem_s [QW+1];
	logic [NumW-1:0] den_s [QW+1];
	logic [QW-1:0]   quo_s [QW+1];
	logic            ovf_s [QW+1];
	logic [NumW-1:0] num;

	assign num = {mag_a, 16'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			den_s[0] <= NumW'(mag_b);
			quo_s[0] <= '0;
			ovf_s[0] <= (num >> QW) >= NumW'(mag_b);
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		localparam int Sh = QW - 1 - k;
		logic ge;
		assign ge = (rem_s[k] >> Sh) >= den_s[k];
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? rem_s[k] - (den_s[k] << Sh) : rem_s[k];
				den_s[k+1] <= den_s[k];
				quo_s[k+1] <= {quo_s[k][QW-2:0], ge};
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	assign quo = quo_s[QW];
	assign ovf = ovf_s[QW];
endmodule

// ===== hw/rtl/vertex_transform_perspective_divide.sv =====
// Top level: 4x4 fixed-point vertex transform with optional divide by w.
// Accepts one beat per cycle while the output is not stalled.
// The latency is set mostly by the 33-step divider pipeline, one quotient bit per stage.
// A stall on the output holds every stage at once; nothing is lost or repeated.
// Reset clears valid bits and loads the identity matrix with divide enabled.
module vertex_transform_perspective_divide (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [127:0]                  s_tdata,  // in_x, in_y, in_z, in_w
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [127:0]                  m_tdata,  // out_x, out_y, out_z, out_w
	output logic [1:0]                    m_tuser,  // divided, saturated
	input  logic                          cfg_we,
	input  logic [vtpd_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [vtpd_pkg::RowW-1:0]     cfg_data
);
	import vtpd_pkg::*;

	localparam int PreLat = 4;
	localparam int VLen   = PreLat + DivLat;

	logic [RowW-1:0] row_q [4];
	logic            div_en_q;
	logic            adv;
	logic [VLen-1:0] valid_q;
	logic            out_valid_q;
	comp_t           vin [4];
	rnd_t            r [4];
	side_t           side_s4;
	side_t           side_d [DivLat];
	logic [MagW-1:0] mag_s4 [4];
	logic [QW-1:0]   quo [3];
	logic            ovf [3];
	logic [31:0]     res [4];
	logic [3:0]      sat;
	logic [127:0]    tdata_q;
	logic [1:0]      tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= Row0Reset;
			row_q[1] <= Row1Reset;
			row_q[2] <= Row2Reset;
			row_q[3] <= Row3Reset;
			div_en_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROW0: row_q[0] <= cfg_data;
				CFG_ROW1: row_q[1] <= cfg_data;
				CFG_ROW2: row_q[2] <= cfg_data;
				CFG_ROW3: row_q[3] <= cfg_data;
				CFG_DIV:  div_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign adv      = !out_valid_q || m_tready;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_q     <= {valid_q[VLen-2:0], s_tvalid};
			out_valid_q <= valid_q[VLen-1];
		end
	end

	for (genvar j = 0; j < 4; j++) begin : g_in
		assign vin[j] = s_tdata[CompW*j +: CompW];
	end

	for (genvar i = 0; i < 4; i++) begin : g_dot
		vtpd_dot u_dot (
			.clk (clk),
			.en  (adv),
			.row (row_q[i]),
			.v   (vin),
			.r   (r[i])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				side_s4.r[i] <= r[i];
				mag_s4[i]    <= r[i][RndW-1] ? MagW'(-r[i]) : r[i];
			end
			for (int i = 0; i < 3; i++) begin
				side_s4.neg[i] <= r[i][RndW-1] ^ r[3][RndW-1];
			end
			side_s4.div <= div_en_q && (r[3] != '0);
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_div
		vtpd_divider u_div (
			.clk   (clk),
			.en    (adv),
			.mag_a (mag_s4[i]),
			.mag_b (mag_s4[3]),
			.quo   (quo[i]),
			.ovf   (ovf[i])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_d[0] <= side_s4;
			for (int k = 1; k < DivLat; k++) begin
				side_d[k] <= side_d[k-1];
			end
		end
	end

	always_comb begin
		side_t sd;
		rnd_t  rv;
		sd = side_d[DivLat-1];
		for (int i = 0; i < 4; i++) begin
			rv = sd.r[i];
			sat[i] = rv[RndW-1] ? !(&rv[RndW-2:31]) : |rv[RndW-2:31];
			if (sat[i]) begin
				res[i] = rv[RndW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			end else begin
				res[i] = rv[31:0];
			end
		end
		if (sd.div) begin
			for (int i = 0; i < 3; i++) begin
				if (!sd.neg[i]) begin
					sat[i] = ovf[i] || quo[i][QW-1] || quo[i][31];
					res[i] = sat[i] ? 32'h7FFF_FFFF : quo[i][31:0];
				end else begin
					sat[i] = ovf[i] || quo[i][QW-1] || (quo[i][31] && |quo[i][30:0]);
					res[i] = sat[i] ? 32'h8000_0000 : 32'(-quo[i][31:0]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tdata_q <= {res[3], res[2], res[1], res[0]};
			tuser_q <= {|sat, side_d[DivLat-1].div};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = tdata_q;
	assign m_tuser  = tuser_q;
endmodule
